[rtl/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and constants for the spanning tree block: item formats,
// cell control groups and the sequencer states.
// ----------------------------------------------------------------------------
package kst_pkg;

   localparam int NODE_FIELD_BITS = 6;
   localparam int COST_FIELD_BITS = 16;
   localparam int TOTAL_BITS      = 22;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 22'h3FFFFF;

   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 256;
   localparam int DEF_COST_BITS = 16;

   typedef struct packed {
      logic [NODE_FIELD_BITS-1:0] edge_from;
      logic [NODE_FIELD_BITS-1:0] edge_to;
      logic [COST_FIELD_BITS-1:0] edge_cost;
      logic                       final_edge;
   } req_type;

   typedef struct packed {
      logic [NODE_FIELD_BITS-1:0] tree_from;
      logic [NODE_FIELD_BITS-1:0] tree_to;
      logic [COST_FIELD_BITS-1:0] tree_cost;
      logic [TOTAL_BITS-1:0]      running_total;
      logic                       tree_done;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } sort_ctl_type;

   typedef struct packed {
      logic init;
      logic merge;
   } node_ctl_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_LOOK,
      S_MERGE,
      S_LAST
   } state_type;

endpackage

[rtl/kruskal_spanning_tree.sv]
// ----------------------------------------------------------------------------
// kruskal_spanning_tree
// Minimum spanning tree over loaded weighted edges, in cost order.
// ----------------------------------------------------------------------------
// Edges are taken one item per cycle, while no run is in progress, into a
// chain of sort cells that keeps them in ascending cost order as they
// arrive, equal costs in arrival order. The edge flagged final starts a run:
// the chain shifts edges out one at a time, and each goes through a label
// lookup in the node cells and then a merge; the lookup waits while the
// result channel stalls. Input items are not taken again until the run
// ends. Each accepted tree edge is one result item; the last carries the
// total and the done flag, and a run that accepts nothing gives one empty
// item with the done flag set.
// ----------------------------------------------------------------------------
module kruskal_spanning_tree
   import kst_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES,
   parameter int COST_BITS = DEF_COST_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NB    = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int CW    = (COST_BITS < COST_FIELD_BITS) ? COST_BITS : COST_FIELD_BITS;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [NB-1:0]          la_ff, la_in, lb_ff, lb_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in, total_sum;
   logic                   pend_vld_ff, pend_vld_in;
   rsp_type                pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   sort_ctl_type           sort_ctl;
   node_ctl_type           node_ctl;
   logic                   req_acc, store_ok;
   logic [CW-1:0]          key_cost;
   logic [TOTAL_BITS:0]    sum_wide;

   logic [NODE_FIELD_BITS-1:0] c_from [MAX_EDGES];
   logic [NODE_FIELD_BITS-1:0] c_to   [MAX_EDGES];
   logic [CW-1:0]              c_cost [MAX_EDGES];
   logic                       c_keep [MAX_EDGES];
   logic [NB-1:0]              pa [MAX_NODES];
   logic [NB-1:0]              pb [MAX_NODES];
   logic [NB-1:0]              look_a, look_b;

   assign req_acc  = req_valid && !req_stall;
   assign key_cost = CW'(req_data.edge_cost);
   assign store_ok = (count_ff < CNT_W'(MAX_EDGES))
                  && ({1'b0, req_data.edge_from} < (NODE_FIELD_BITS + 1)'(MAX_NODES))
                  && ({1'b0, req_data.edge_to} < (NODE_FIELD_BITS + 1)'(MAX_NODES));

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_sort
      logic [NODE_FIELD_BITS-1:0] lf, lt, rf, rt;
      logic [CW-1:0]              lc, rc;
      logic                       lk;
      if (i == 0) begin : g_first
         assign lf = req_data.edge_from;
         assign lt = req_data.edge_to;
         assign lc = key_cost;
         assign lk = 1'b1;
      end else begin : g_mid
         assign lf = c_from[i-1];
         assign lt = c_to[i-1];
         assign lc = c_cost[i-1];
         assign lk = c_keep[i-1];
      end
      if (i == MAX_EDGES - 1) begin : g_last
         assign rf = '0;
         assign rt = '0;
         assign rc = '0;
      end else begin : g_inner
         assign rf = c_from[i+1];
         assign rt = c_to[i+1];
         assign rc = c_cost[i+1];
      end
      kst_sort_cell #(.COST_W(CW), .CNT_W(CNT_W), .INDEX(i)) u_cell (
         .clock      (clock),
         .ctl        (sort_ctl),
         .count      (count_ff),
         .key_from   (req_data.edge_from),
         .key_to     (req_data.edge_to),
         .key_cost   (key_cost),
         .left_from  (lf),
         .left_to    (lt),
         .left_cost  (lc),
         .left_keep  (lk),
         .right_from (rf),
         .right_to   (rt),
         .right_cost (rc),
         .cell_from  (c_from[i]),
         .cell_to    (c_to[i]),
         .cell_cost  (c_cost[i]),
         .keep       (c_keep[i])
      );
   end

   for (genvar n = 0; n < MAX_NODES; n++) begin : g_node
      kst_node_cell #(.NB(NB), .INDEX(n)) u_node (
         .clock   (clock),
         .reset   (reset),
         .ctl     (node_ctl),
         .node_a  (c_from[0]),
         .node_b  (c_to[0]),
         .label_a (la_ff),
         .label_b (lb_ff),
         .part_a  (pa[n]),
         .part_b  (pb[n])
      );
   end

   always_comb begin
      look_a = '0;
      look_b = '0;
      for (int n = 0; n < MAX_NODES; n++) begin
         look_a = look_a | pa[n];
         look_b = look_b | pb[n];
      end
   end

   always_comb begin
      sum_wide  = {1'b0, total_ff} + (TOTAL_BITS + 1)'(c_cost[0]);
      total_sum = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_wide[TOTAL_BITS-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_acc && req_data.final_edge) state_in = S_LOOK;
         end
         S_LOOK: begin
            if (!rsp_valid_ff) state_in = (count_ff == '0) ? S_LAST : S_MERGE;
         end
         S_MERGE: state_in = S_LOOK;
         S_LAST: begin
            if (!rsp_valid_ff) state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != S_LOAD);
      sort_ctl.insert = (state_ff == S_LOAD) && req_acc && store_ok;
      sort_ctl.shift  = (state_ff == S_MERGE);
      node_ctl.init   = (state_ff == S_LOAD) && req_acc && req_data.final_edge;
      node_ctl.merge  = (state_ff == S_MERGE) && (la_ff != lb_ff);

      count_in     = count_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      total_in     = total_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (sort_ctl.insert) count_in = count_ff + CNT_W'(1);
      if (sort_ctl.shift)  count_in = count_ff - CNT_W'(1);
      if (node_ctl.init) begin
         total_in    = '0;
         pend_vld_in = 1'b0;
      end
      if (state_ff == S_LOOK) begin
         la_in = look_a;
         lb_in = look_b;
      end
      if (node_ctl.merge) begin
         total_in                = total_sum;
         pend_vld_in             = 1'b1;
         pend_in.tree_from       = c_from[0];
         pend_in.tree_to         = c_to[0];
         pend_in.tree_cost       = COST_FIELD_BITS'(c_cost[0]);
         pend_in.running_total   = total_sum;
         pend_in.tree_done       = 1'b0;
         if (pend_vld_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pend_ff;
         end
      end
      if ((state_ff == S_LAST) && !rsp_valid_ff) begin
         count_in     = '0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_vld_ff ? pend_ff : '0;
         rsp_data_in.tree_done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond store depth");

   a_same_root_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE && la_ff == lb_ff) |=> $stable(total_ff))
      else $error("total changed on a rejected edge");

   a_merge_emits: assert property (@(posedge clock) disable iff (reset)
      (node_ctl.merge && pend_vld_ff) |=> rsp_valid_ff)
      else $error("held tree edge not emitted on next accept");

   a_run_ends_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAST && !rsp_valid_ff) |=> (rsp_valid_ff && rsp_data_ff.tree_done))
      else $error("run closed without a done item");
`endif

endmodule

[rtl/kst_sort_cell.sv]
// ----------------------------------------------------------------------------
// kst_sort_cell
// One slot of the sorted edge chain. On insert it keeps its edge, takes the
// new edge or takes its left neighbor's edge; on shift it takes the right one.
// ----------------------------------------------------------------------------
module kst_sort_cell
   import kst_pkg::*;
#(
   parameter int COST_W = 16,
   parameter int CNT_W  = 9,
   parameter int INDEX  = 0
) (
   input  logic                       clock,
   input  sort_ctl_type               ctl,
   input  logic [CNT_W-1:0]           count,
   input  logic [NODE_FIELD_BITS-1:0] key_from,
   input  logic [NODE_FIELD_BITS-1:0] key_to,
   input  logic [COST_W-1:0]          key_cost,
   input  logic [NODE_FIELD_BITS-1:0] left_from,
   input  logic [NODE_FIELD_BITS-1:0] left_to,
   input  logic [COST_W-1:0]          left_cost,
   input  logic                       left_keep,
   input  logic [NODE_FIELD_BITS-1:0] right_from,
   input  logic [NODE_FIELD_BITS-1:0] right_to,
   input  logic [COST_W-1:0]          right_cost,
   output logic [NODE_FIELD_BITS-1:0] cell_from,
   output logic [NODE_FIELD_BITS-1:0] cell_to,
   output logic [COST_W-1:0]          cell_cost,
   output logic                       keep
);

   logic [NODE_FIELD_BITS-1:0] from_ff, from_in;
   logic [NODE_FIELD_BITS-1:0] to_ff, to_in;
   logic [COST_W-1:0]          cost_ff, cost_in;

   assign keep = (CNT_W'(INDEX) < count) && (cost_ff <= key_cost);

   always_comb begin
      from_in = from_ff;
      to_in   = to_ff;
      cost_in = cost_ff;
      if (ctl.insert && !keep) begin
         if (left_keep) begin
            from_in = key_from;
            to_in   = key_to;
            cost_in = key_cost;
         end else begin
            from_in = left_from;
            to_in   = left_to;
            cost_in = left_cost;
         end
      end else if (ctl.shift) begin
         from_in = right_from;
         to_in   = right_to;
         cost_in = right_cost;
      end
   end

   always_ff @(posedge clock) begin
      from_ff <= from_in;
      to_ff   <= to_in;
      cost_ff <= cost_in;
   end

   assign cell_from = from_ff;
   assign cell_to   = to_ff;
   assign cell_cost = cost_ff;

endmodule

[rtl/kst_node_cell.sv]
// ----------------------------------------------------------------------------
// kst_node_cell
// Component label of one node. It answers lookups for both endpoints and
// relabels itself when its component is merged into another.
// ----------------------------------------------------------------------------
module kst_node_cell
   import kst_pkg::*;
#(
   parameter int NB    = 6,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  node_ctl_type               ctl,
   input  logic [NODE_FIELD_BITS-1:0] node_a,
   input  logic [NODE_FIELD_BITS-1:0] node_b,
   input  logic [NB-1:0]              label_a,
   input  logic [NB-1:0]              label_b,
   output logic [NB-1:0]              part_a,
   output logic [NB-1:0]              part_b
);

   logic [NB-1:0] label_ff, label_in;

   assign part_a = (node_a == NODE_FIELD_BITS'(INDEX)) ? label_ff : '0;
   assign part_b = (node_b == NODE_FIELD_BITS'(INDEX)) ? label_ff : '0;

   always_comb begin
      label_in = label_ff;
      if (ctl.init) begin
         label_in = NB'(INDEX);
      end else if (ctl.merge && (label_ff == label_b)) begin
         label_in = label_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff <= NB'(INDEX);
      end else begin
         label_ff <= label_in;
      end
   end

endmodule
